FILE: rtl/itoa_pkg.sv
// Shared constants, types and the digit-to-character function for the radix string converter.
package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int VALUE_BITS      = 32;
    localparam int RADIX_BITS      = 6;
    localparam int DIGIT_BITS      = 6;
    localparam int CHAR_BITS       = 8;
    localparam int S_TDATA_BITS    = 40;
    localparam int BITS_PER_CYCLE  = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO     = 8'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS    = 8'd45;
    localparam logic [CHAR_BITS-1:0] LETTER_OFFSET = 8'd87;
    localparam logic [DIGIT_BITS-1:0] DIGIT_MAX_DEC = 6'd9;

    typedef struct packed {
        logic load;
        logic div_run;
        logic rd;
        logic put_sign;
        logic put_digit;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic step_last;
        logic q_zero;
        logic last_digit;
        logic neg;
    } sts_t;

    function automatic logic [CHAR_BITS-1:0] ascii_of_digit(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] dx;
        dx = {2'b00, d};
        return (d <= DIGIT_MAX_DEC) ? dx + CHAR_ZERO : dx + LETTER_OFFSET;
    endfunction

endpackage

FILE: rtl/itoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/itoa_ctrl.sv
// Controller state machine: divide loop, optional sign, then digit readout.
module itoa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  itoa_pkg::sts_t sts,
    output itoa_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SIGN = 5'b00100,
        S_READ = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_run = 1'b1;
                // a zero quotient after a full digit ends the loop
                if (sts.step_last && sts.q_zero)
                begin
                    state_next = sts.neg ? S_SIGN : S_READ;
                end
            end
            S_SIGN:
            begin
                if (sts.slot_free)
                begin
                    cmd.put_sign = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.put_digit = 1'b1;
                    state_next    = sts.last_digit ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/itoa_dp.sv
// Datapath: magnitude and radix load, 8-bit-per-cycle divider, digit stack, output register.
module itoa_dp #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_op,
    input  logic [itoa_pkg::VALUE_BITS-1:0]      in_value,
    input  logic [itoa_pkg::RADIX_BITS-1:0]      in_radix,
    input  itoa_pkg::cmd_t                       cmd,
    output itoa_pkg::sts_t                       sts,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [itoa_pkg::CHAR_BITS-1:0]       m_tdata,
    output logic                                 m_tlast
);

    localparam int BPC   = itoa_pkg::BITS_PER_CYCLE;
    localparam int DW    = ((VALUE_WIDTH + BPC - 1) / BPC) * BPC;
    localparam int STEPS = DW / BPC;
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int CW    = $clog2(VALUE_WIDTH + 1);
    localparam int AW    = $clog2(VALUE_WIDTH);
    localparam int RB    = itoa_pkg::RADIX_BITS;
    localparam int DB    = itoa_pkg::DIGIT_BITS;

    logic [DW-1:0]                     q_reg;
    logic [DB-1:0]                     rem_reg;
    logic [RB-1:0]                     radix_reg;
    logic                              neg_reg;
    logic [SW-1:0]                     step_reg;
    logic [CW-1:0]                     count_reg;
    logic                              m_tvalid_reg;
    logic [itoa_pkg::CHAR_BITS-1:0]    m_tdata_reg;
    logic                              m_tlast_reg;

    logic [VALUE_WIDTH-1:0]            v;
    logic [VALUE_WIDTH-1:0]            mag;
    logic                              neg_in;
    logic [RB-1:0]                     radix_clamped;
    logic [DW-1:0]                     q_step;
    logic [DB-1:0]                     rem_step;
    logic                              step_last;
    logic [CW-1:0]                     count_dec;
    logic [DB-1:0]                     ram_rdata;

    always_comb
    begin
        v      = VALUE_WIDTH'(in_value);
        neg_in = !in_op && v[VALUE_WIDTH-1];
        mag    = neg_in ? (~v + VALUE_WIDTH'(1)) : v;
        if (in_radix < itoa_pkg::RADIX_MIN)
        begin
            radix_clamped = itoa_pkg::RADIX_MIN;
        end
        else if (in_radix > itoa_pkg::RADIX_MAX)
        begin
            radix_clamped = itoa_pkg::RADIX_MAX;
        end
        else
        begin
            radix_clamped = in_radix;
        end
    end

    // restoring long division, BPC quotient bits per cycle, narrow remainder
    always_comb
    begin
        logic [DB:0] t;
        logic [DB:0] rx;
        rx       = {1'b0, radix_reg};
        rem_step = rem_reg;
        q_step   = q_reg;
        for (int i = 0; i < BPC; i++)
        begin
            t      = {rem_step, q_step[DW-1]};
            q_step = {q_step[DW-2:0], 1'b0};
            if (t >= rx)
            begin
                rem_step  = DB'(t - rx);
                q_step[0] = 1'b1;
            end
            else
            begin
                rem_step = t[DB-1:0];
            end
        end
    end

    assign step_last = (step_reg == SW'(STEPS - 1));
    assign count_dec = count_reg - CW'(1);

    itoa_ram #(
        .WIDTH (DB),
        .DEPTH (VALUE_WIDTH)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.div_run && step_last),
        .waddr (count_reg[AW-1:0]),
        .wdata (rem_step),
        .re    (cmd.rd),
        .raddr (count_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg      <= 1'b0;
            step_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                neg_reg   <= neg_in;
                step_reg  <= '0;
                count_reg <= '0;
            end
            else if (cmd.div_run)
            begin
                if (step_last)
                begin
                    step_reg  <= '0;
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    step_reg <= step_reg + SW'(1);
                end
            end
            else if (cmd.put_digit)
            begin
                count_reg <= count_dec;
            end

            if (cmd.put_sign || cmd.put_digit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg     <= DW'(mag);
            rem_reg   <= '0;
            radix_reg <= radix_clamped;
        end
        else if (cmd.div_run)
        begin
            q_reg   <= q_step;
            // start each digit with a clear remainder
            rem_reg <= step_last ? '0 : rem_step;
        end

        if (cmd.put_sign)
        begin
            m_tdata_reg <= itoa_pkg::CHAR_MINUS;
            m_tlast_reg <= 1'b0;
        end
        else if (cmd.put_digit)
        begin
            m_tdata_reg <= itoa_pkg::ascii_of_digit(ram_rdata);
            m_tlast_reg <= (count_reg == CW'(1));
        end
    end

    always_comb
    begin
        sts.slot_free  = !m_tvalid_reg || m_tready;
        sts.step_last  = step_last;
        sts.q_zero     = (q_step == '0);
        sts.last_digit = (count_reg == CW'(1));
        sts.neg        = neg_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: rtl/integer_to_radix_string_top.sv
// Top level of the integer to radix string converter.
// Converts one 32-bit number per input item into its ASCII text in radix 2 to 36 (radix
// outside that range is clamped), most significant digit first, one character per output
// item, with m_tlast on the final character; a signed negative number gets a leading '-',
// zero gives "0", digits above 9 are lower-case letters. One number is worked at a time:
// the input is taken in the idle state, then each digit is worked out in the divider, which
// retires 8 quotient bits per cycle over the whole quotient, and each character is read
// from the digit stack RAM, which has a registered read, and then put into the output
// register; the sign and each character wait while the output side stalls.
module integer_to_radix_string_top #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [itoa_pkg::S_TDATA_BITS-1:0]   s_tdata,   // [31:0] value, [37:32] radix
    input  logic                                s_tuser,   // [0] op: 0 signed, 1 unsigned
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [itoa_pkg::CHAR_BITS-1:0]      m_tdata,   // [7:0] character
    output logic                                m_tlast
);

    localparam int VB = itoa_pkg::VALUE_BITS;
    localparam int RB = itoa_pkg::RADIX_BITS;

    itoa_pkg::cmd_t cmd;
    itoa_pkg::sts_t sts;

    itoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_op    (s_tuser),
        .in_value (s_tdata[VB-1:0]),
        .in_radix (s_tdata[VB+RB-1:VB]),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
